FILE: rtl/lcs_pkg.sv
// Shared item types and request codes for the longest common substring block.
package lcs_pkg;

   // Width of the result length and start fields
   localparam int OUT_W = 9;

   // Request codes
   localparam logic [1:0] REQ_APPEND_A = 2'd0;
   localparam logic [1:0] REQ_APPEND_B = 2'd1;
   localparam logic [1:0] REQ_RUN      = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] symbol;
   } req_item_type;

   typedef struct packed {
      logic [OUT_W-1:0] match_length;
      logic [OUT_W-1:0] match_start;
      logic             overflowed;
   } rsp_item_type;

endpackage

FILE: rtl/longest_common_substring_top.sv
// Load items are taken one per cycle while no run is in progress; a run item sweeps
// the DP table cell by cell: one compare/increment unit reads a cell and then updates it.
// An empty string skips the sweep. The input stays stalled until the result is registered.
// Synchronous active-high reset clears lengths, flags, sequencer and result
// valid; the string and row RAMs are not cleared and need no clearing pass.
module longest_common_substring_top
   import lcs_pkg::*;
#(
   parameter int MAX_LEN = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = $clog2(MAX_LEN);

   // Sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_ROW     = 3'd1;
   localparam logic [2:0] S_CELL_RD = 3'd2;
   localparam logic [2:0] S_CELL_EX = 3'd3;
   localparam logic [2:0] S_DONE    = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [LW-1:0] len_a_ff, len_a_in;
   logic [LW-1:0] len_b_ff, len_b_in;
   logic          drop_ff, drop_in;
   logic [LW-1:0] ai_ff, ai_in;
   logic [LW-1:0] bj_ff, bj_in;
   logic [LW-1:0] diag_ff, diag_in;
   logic [LW-1:0] best_len_ff, best_len_in;
   logic [LW-1:0] best_end_ff, best_end_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_item_ff, rsp_item_in;

   logic          req_accept;
   logic          a_we, b_we, p_we;
   logic          a_re, bp_re;
   logic [7:0]    a_rd, b_rd;
   logic [LW-1:0] p_rd;
   logic [LW-1:0] above;
   logic [LW-1:0] cell_len;
   logic          sym_match;
   logic          row_end, col_end;
   logic          rsp_free;
   logic [LW-1:0] start_idx;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // String stores: written on loads, read during the sweep
   assign a_we  = req_accept && (req_item.req_type == REQ_APPEND_A)
                  && (len_a_ff < LW'(MAX_LEN));
   assign b_we  = req_accept && (req_item.req_type == REQ_APPEND_B)
                  && (len_b_ff < LW'(MAX_LEN));
   assign a_re  = (state_ff == S_ROW);
   assign bp_re = (state_ff == S_CELL_RD);

   lcs_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_str_a (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (len_a_ff[AW-1:0]),
      .wr_data (req_item.symbol),
      .rd_en   (a_re),
      .rd_addr (ai_ff[AW-1:0]),
      .rd_data (a_rd)
   );

   lcs_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_str_b (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (len_b_ff[AW-1:0]),
      .wr_data (req_item.symbol),
      .rd_en   (bp_re),
      .rd_addr (bj_ff[AW-1:0]),
      .rd_data (b_rd)
   );

   // Previous DP row; row 0 is implied zero, so no clearing is needed
   lcs_ram #(.WIDTH(LW), .DEPTH(MAX_LEN)) u_prev_row (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (bj_ff[AW-1:0]),
      .wr_data (cell_len),
      .rd_en   (bp_re),
      .rd_addr (bj_ff[AW-1:0]),
      .rd_data (p_rd)
   );

   // Cell unit: one compare and one increment
   assign above     = (ai_ff == '0) ? '0 : p_rd;
   assign sym_match = (a_rd == b_rd);
   assign cell_len  = sym_match ? (diag_ff + LW'(1)) : '0;
   assign p_we      = (state_ff == S_CELL_EX);
   assign col_end   = (bj_ff == (len_b_ff - LW'(1)));
   assign row_end   = (ai_ff == (len_a_ff - LW'(1)));
   assign start_idx = best_end_ff - best_len_ff;

   // Sequencer and load handling
   always_comb begin
      state_in     = state_ff;
      len_a_in     = len_a_ff;
      len_b_in     = len_b_ff;
      drop_in      = drop_ff;
      ai_in        = ai_ff;
      bj_in        = bj_ff;
      diag_in      = diag_ff;
      best_len_in  = best_len_ff;
      best_end_in  = best_end_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (req_item.req_type)
                  REQ_APPEND_A: begin
                     if (a_we) len_a_in = len_a_ff + LW'(1);
                     else      drop_in  = 1'b1;
                  end
                  REQ_APPEND_B: begin
                     if (b_we) len_b_in = len_b_ff + LW'(1);
                     else      drop_in  = 1'b1;
                  end
                  REQ_RUN: begin
                     best_len_in = '0;
                     best_end_in = len_a_ff;
                     ai_in       = '0;
                     if ((len_a_ff == '0) || (len_b_ff == '0)) state_in = S_DONE;
                     else                                      state_in = S_ROW;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ROW: begin
            bj_in    = '0;
            diag_in  = '0;
            state_in = S_CELL_RD;
         end
         S_CELL_RD: begin
            state_in = S_CELL_EX;
         end
         S_CELL_EX: begin
            // Keep the first strict maximum
            if (sym_match && (cell_len > best_len_ff)) begin
               best_len_in = cell_len;
               best_end_in = ai_ff + LW'(1);
            end
            diag_in = above;
            if (col_end) begin
               if (row_end) begin
                  state_in = S_DONE;
               end else begin
                  ai_in    = ai_ff + LW'(1);
                  state_in = S_ROW;
               end
            end else begin
               bj_in    = bj_ff + LW'(1);
               state_in = S_CELL_RD;
            end
         end
         S_DONE: begin
            // Hold until the result register is free, then clear the strings
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.match_length = OUT_W'(best_len_ff);
               rsp_item_in.match_start  = OUT_W'(start_idx);
               rsp_item_in.overflowed   = drop_ff;
               len_a_in                 = '0;
               len_b_in                 = '0;
               drop_in                  = 1'b0;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         drop_ff      <= 1'b0;
         best_len_ff  <= '0;
         best_end_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         drop_ff      <= drop_in;
         best_len_ff  <= best_len_in;
         best_end_ff  <= best_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      ai_ff       <= ai_in;
      bj_ff       <= bj_in;
      diag_ff     <= diag_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef ASSERT_OFF
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside the done step");

   a_strings_cleared: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ((len_a_ff == '0) && (len_b_ff == '0) && !drop_ff))
      else $error("strings not cleared with the result");

   a_best_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> ((best_len_ff <= len_a_ff) && (best_len_ff <= len_b_ff)))
      else $error("best length exceeds a string length");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_CELL_RD) || (state_ff == S_CELL_EX)) |-> (bj_ff < len_b_ff))
      else $error("column index beyond string B");
`endif

endmodule

FILE: rtl/lcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: test/tb_longest_common_substring_top.sv
// Self-checking testbench for the longest common substring block.
module tb_longest_common_substring_top import lcs_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LEN = 256;
   localparam int IDLE_LIMIT = 600000;
   localparam int TOTAL_ITEMS = 1250;
   // The fourth request code has no meaning and must be ignored
   localparam logic [1:0] REQ_IGNORED = 2'd3;

   typedef logic [7:0] char_q_type [$];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   // Shadow copy of the strings held by the block
   logic [7:0] a_chars [MAX_LEN];
   logic [7:0] b_chars [MAX_LEN];
   int a_len = 0;
   int b_len = 0;
   bit dropped = 1'b0;

   rsp_item_type match_q [$];
   int errors = 0;
   int load_count = 0;
   int quiet_cycles = 0;
   bit steady_flow = 1'b0;

   longest_common_substring_top #(
      .MAX_LEN(MAX_LEN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item)
   );

   always #1 clock = ~clock;

   // Sweep the run-length row over both strings; keep the first strict maximum
   function automatic rsp_item_type compute_lcs();
      int row [0:MAX_LEN];
      int diag;
      int above;
      int run_len;
      int best_len;
      int best_end;
      rsp_item_type r;
      foreach (row[k]) row[k] = 0;
      best_len = 0;
      best_end = a_len;
      for (int i = 1; i <= a_len; i++) begin
         diag = row[0];
         for (int j = 1; j <= b_len; j++) begin
            above = row[j];
            run_len = 0;
            if (a_chars[i-1] == b_chars[j-1]) begin
               run_len = diag + 1;
               if (run_len > best_len) begin
                  best_len = run_len;
                  best_end = i;
               end
            end
            row[j] = run_len;
            diag = above;
         end
      end
      r.match_length = OUT_W'(best_len);
      r.match_start = OUT_W'(best_end - best_len);
      r.overflowed = dropped;
      return r;
   endfunction

   // Update the shadow strings with one accepted item
   task automatic track_item(input req_item_type it);
      case (it.req_type)
         REQ_APPEND_A: begin
            if (a_len < MAX_LEN) begin
               a_chars[a_len] = it.symbol;
               a_len++;
            end else begin
               dropped = 1'b1;
            end
         end
         REQ_APPEND_B: begin
            if (b_len < MAX_LEN) begin
               b_chars[b_len] = it.symbol;
               b_len++;
            end else begin
               dropped = 1'b1;
            end
         end
         REQ_RUN: begin
            match_q = {match_q, compute_lcs()};
            a_len = 0;
            b_len = 0;
            dropped = 1'b0;
         end
         default: ;
      endcase
   endtask

   // Offer one item after a random gap and hold it until accepted
   task automatic send_item(input logic [1:0] kind, input logic [7:0] sym);
      int gap;
      req_item_type it;
      it.req_type = kind;
      it.symbol = sym;
      gap = steady_flow ? 0 : $urandom_range(0, 8);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
      track_item(it);
      load_count++;
   endtask

   // Drop valid and wait until every pending result has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (match_q.size() != 0) @(posedge clock);
   endtask

   function automatic char_q_type text(input string s);
      char_q_type q;
      foreach (s[k]) q = {q, s[k]};
      return q;
   endfunction

   function automatic char_q_type random_text(input int len, input logic [7:0] base,
                                              input int span);
      char_q_type q;
      for (int k = 0; k < len; k++) q = {q, base + 8'($urandom_range(0, span))};
      return q;
   endfunction

   // Interleave the loads of both strings, optionally with junk, then run
   task automatic load_and_run(input char_q_type sa, input char_q_type sb, input bit noise);
      int ia;
      int ib;
      ia = 0;
      ib = 0;
      while (ia < sa.size() || ib < sb.size()) begin
         if (noise && $urandom_range(0, 15) == 0) begin
            send_item(REQ_IGNORED, 8'($urandom));
         end else if (ib >= sb.size() || (ia < sa.size() && $urandom_range(0, 1) == 0)) begin
            send_item(REQ_APPEND_A, sa[ia]);
            ia++;
         end else begin
            send_item(REQ_APPEND_B, sb[ib]);
            ib++;
         end
      end
      send_item(REQ_RUN, 8'($urandom));
   endtask

   // Runs with one or both strings empty
   task automatic test_empty_strings();
      char_q_type none;
      load_and_run(none, none, 1'b0);
      load_and_run(text("abc"), none, 1'b0);
      load_and_run(none, text("xy"), 1'b0);
   endtask

   // Plain matches, a tie between equal maxima and the extreme byte values
   task automatic test_matches();
      char_q_type lo_hi;
      char_q_type hi_lo;
      lo_hi = '{8'h00, 8'hFF, 8'hFF};
      hi_lo = '{8'hFF, 8'hFF, 8'h00};
      load_and_run(text("q"), text("q"), 1'b0);
      load_and_run(text("abcde"), text("xbcdy"), 1'b0);
      load_and_run(text("xyab"), text("abxy"), 1'b0);
      load_and_run(lo_hi, hi_lo, 1'b0);
   endtask

   // Junk request codes in between loads change nothing
   task automatic test_ignored_requests();
      send_item(REQ_IGNORED, 8'hFF);
      send_item(REQ_APPEND_A, "a");
      send_item(REQ_IGNORED, 8'h00);
      send_item(REQ_APPEND_B, "a");
      send_item(REQ_APPEND_A, "b");
      send_item(REQ_IGNORED, "b");
      send_item(REQ_APPEND_B, "b");
      send_item(REQ_RUN, 8'h00);
   endtask

   // Full strings, dropped characters and the flag clearing after a run
   task automatic test_string_full();
      char_q_type none;
      char_q_type full;
      char_q_type longer;
      full = random_text(MAX_LEN, 8'h00, 255);
      longer = full;
      longer = {longer, 8'h5A};
      load_and_run(random_text(MAX_LEN + 1, 8'h40, 3), text("AB"), 1'b0);
      load_and_run(none, none, 1'b0);
      // Largest result: whole strings equal, one extra character dropped
      load_and_run(full, longer, 1'b0);
   endtask

   // Hold off the sender until the block has answered every run
   task automatic test_pressure();
      for (int k = 0; k < 3; k++) begin
         load_and_run(random_text(6, 8'h61, 3), random_text(5, 8'h61, 3), 1'b0);
         wait_for_results();
      end
   endtask

   // Random strings over narrow and wide alphabets, often with a planted match
   task automatic test_random();
      int la;
      int lb;
      int span;
      int seg;
      int from;
      int to;
      logic [7:0] base;
      char_q_type sa;
      char_q_type sb;
      while (load_count < TOTAL_ITEMS) begin
         steady_flow = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 19) == 0) begin
            la = $urandom_range(0, 40);
            lb = $urandom_range(0, 40);
         end else begin
            la = $urandom_range(0, 10);
            lb = $urandom_range(0, 10);
         end
         case ($urandom_range(0, 2))
            0: span = 1;
            1: span = 3;
            default: span = 255;
         endcase
         base = 8'($urandom);
         sa = random_text(la, base, span);
         sb = random_text(lb, base, span);
         if (la > 0 && lb > 0 && $urandom_range(0, 1) == 1) begin
            seg = $urandom_range(1, (la < lb) ? la : lb);
            from = $urandom_range(0, la - seg);
            to = $urandom_range(0, lb - seg);
            for (int k = 0; k < seg; k++) sb[to + k] = sa[from + k];
         end
         load_and_run(sa, sb, $urandom_range(0, 3) == 0);
      end
      steady_flow = 1'b0;
   endtask

   // Stall the result side for a random number of cycles per item
   always begin : rsp_pacer
      int hold;
      hold = steady_flow ? 0 : $urandom_range(0, 8);
      if (hold > 0) begin
         @(negedge clock);
         rsp_stall <= 1'b1;
         repeat (hold - 1) @(negedge clock);
      end
      @(negedge clock);
      rsp_stall <= 1'b0;
      do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
   end

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (match_q.size() == 0) begin
            $error("unexpected result: match_length %0d match_start %0d overflowed %0d",
                   rsp_item.match_length, rsp_item.match_start, rsp_item.overflowed);
            errors++;
         end else begin
            want = match_q.pop_front();
            if (rsp_item.match_length !== want.match_length) begin
               $error("match_length: expected %0d, actual %0d",
                      want.match_length, rsp_item.match_length);
               errors++;
            end
            if (rsp_item.match_start !== want.match_start) begin
               $error("match_start: expected %0d, actual %0d",
                      want.match_start, rsp_item.match_start);
               errors++;
            end
            if (rsp_item.overflowed !== want.overflowed) begin
               $error("overflowed: expected %0d, actual %0d",
                      want.overflowed, rsp_item.overflowed);
               errors++;
            end
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_strings();
      test_matches();
      test_ignored_requests();
      test_string_full();
      test_pressure();
      test_random();
      wait_for_results();
      repeat (20) @(posedge clock);
      if (errors == 0 && match_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/lcs_pkg.sv
rtl/lcs_ram.sv
rtl/longest_common_substring_top.sv
test/tb_longest_common_substring_top.sv
